// File: rtl/core/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

  localparam int SQRT_STEPS = 23;  // one root bit per cell
  localparam int DIV_STEPS  = 23;  // one quotient bit per cell
  localparam int LANES      = 3;
  localparam logic signed [18:0] Q_ONE = 19'sd16384;

  typedef enum logic [1:0] {
    PATH_TRACE = 2'd0,
    PATH_X     = 2'd1,
    PATH_Y     = 2'd2,
    PATH_Z     = 2'd3
  } path_t;

  typedef struct packed {
    path_t                  path;
    logic [2:0]             sign;
    logic [2:0][16:0]       mag;
    logic [17:0]            rad;   // radicand pairs still to consume, msb first
    logic [23:0]            rem;
    logic [22:0]            root;
  } sqrt_word_t;

  typedef struct packed {
    path_t                  path;
    logic [2:0]             sign;
    logic [23:0]            den;   // 2*S
    logic [2:0][23:0]       rem;
    logic [2:0][22:0]       numlo; // numerator bits still to bring down
    logic [2:0][22:0]       quo;
  } div_word_t;

endpackage

// File: rtl/core/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion pipeline built from a row of cells.
//
//  channel  dir  tdata (lsb first)                      tuser
//  s_       in   m00 m01 m02 m10 m11 m12 m20 m21 m22    -
//  m_       out  qw qx qy qz                            path_taken
//
// One word per cycle while m_ does not stall; stages: front cell, 23 root cells,
// 23 quotient cells, output register. Each root or quotient cell resolves one
// bit, so the bit counts set the depth. Reset (rst, synchronous) empties every
// cell. Each cell advances when it is empty or its neighbor takes its word, so a
// stall at m_ only fills the row behind it; s_tready drops once all are full.
module rotation_matrix_to_quaternion (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // qw qx qy qz
  output logic [1:0]   m_tuser    // path_taken
);

  localparam int NS = rmq_pkg::SQRT_STEPS;
  localparam int ND = rmq_pkg::DIV_STEPS;

  rmq_pkg::sqrt_word_t sq_w [NS+1];
  logic [NS:0]         sq_v;
  logic [NS:0]         sq_r;
  rmq_pkg::div_word_t  dv_w [ND+1];
  logic [ND:0]         dv_v;
  logic [ND:0]         dv_r;

  rmq_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .out_valid(sq_v[0]), .out_ready(sq_r[0]), .out_word(sq_w[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(sq_v[k]), .in_ready(sq_r[k]), .in_word(sq_w[k]),
      .out_valid(sq_v[k+1]), .out_ready(sq_r[k+1]), .out_word(sq_w[k+1])
    );
  end

  // root done: numerator = mag*2^21 + S, divisor = 2*S
  logic [37:0] num [3];
  always_comb begin
    dv_w[0]      = '0;
    dv_w[0].path = sq_w[NS].path;
    dv_w[0].sign = sq_w[NS].sign;
    dv_w[0].den  = {sq_w[NS].root, 1'b0};
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      num[l] = {sq_w[NS].mag[l], 21'd0} + {15'd0, sq_w[NS].root};
      dv_w[0].rem[l]   = {9'd0, num[l][37:23]};
      dv_w[0].numlo[l] = num[l][22:0];
    end
  end
  assign dv_v[0]  = sq_v[NS];
  assign sq_r[NS] = dv_r[0];

  for (genvar k = 0; k < ND; k++) begin : g_div
    rmq_div_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(dv_v[k]), .in_ready(dv_r[k]), .in_word(dv_w[k]),
      .out_valid(dv_v[k+1]), .out_ready(dv_r[k+1]), .out_word(dv_w[k+1])
    );
  end

  // rounding already folded into the numerator; apply sign and saturate, then order the lanes by path
  logic [23:0] big_sum;
  logic [15:0] big;
  logic [15:0] lane [3];
  logic [15:0] qw_n, qx_n, qy_n, qz_n;
  logic        out_v;
  logic [63:0] out_data;
  logic [1:0]  out_path;
  logic        out_ready_in;

  assign big_sum = {1'b0, dv_w[ND].den[23:1]} + 24'd128;
  assign big     = big_sum[23:8];

  always_comb begin
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      if (dv_w[ND].sign[l]) begin
        lane[l] = (dv_w[ND].quo[l] >= 23'd32768) ? 16'h8000
                                                 : 16'(-dv_w[ND].quo[l][15:0]);
      end else begin
        lane[l] = (dv_w[ND].quo[l] > 23'd32767) ? 16'h7fff : dv_w[ND].quo[l][15:0];
      end
    end
    case (dv_w[ND].path)
      rmq_pkg::PATH_TRACE: begin
        qw_n = big; qx_n = lane[0]; qy_n = lane[1]; qz_n = lane[2];
      end
      rmq_pkg::PATH_X: begin
        qw_n = lane[0]; qx_n = big; qy_n = lane[1]; qz_n = lane[2];
      end
      rmq_pkg::PATH_Y: begin
        qw_n = lane[0]; qx_n = lane[2]; qy_n = big; qz_n = lane[1];
      end
      default: begin
        qw_n = lane[0]; qx_n = lane[1]; qy_n = lane[2]; qz_n = big;
      end
    endcase
  end

  assign out_ready_in = !out_v || m_tready;
  assign dv_r[ND]     = out_ready_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_ready_in) begin
      out_v <= dv_v[ND];
    end
    if (out_ready_in && dv_v[ND]) begin
      out_data <= {qz_n, qy_n, qx_n, qw_n};
      out_path <= dv_w[ND].path;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_data;
  assign m_tuser  = out_path;

`ifndef ASSERT_OFF
  a_trace_w_nonneg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rmq_pkg::PATH_TRACE |-> !m_tdata[15])
    else $error("trace path gave negative qw");
  a_x_nonneg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rmq_pkg::PATH_X |-> !m_tdata[31])
    else $error("x path gave negative qx");
  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    dv_v[0] |-> dv_w[0].den >= 24'd32768)
    else $error("root below clamp floor");
`endif

endmodule

// File: rtl/core/rmq_front.sv
// Input cell: trace, branch select, radicand and off-diagonal sums and differences.
module rmq_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [143:0]             in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rmq_pkg::sqrt_word_t      out_word
);

  logic                  valid;
  rmq_pkg::sqrt_word_t   word;
  rmq_pkg::sqrt_word_t   word_next;

  logic signed [18:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [18:0] tr, r;
  logic signed [18:0] d0, d1, d2;
  logic signed [17:0] d [3];
  logic signed [17:0] dn;
  rmq_pkg::path_t     path;

  assign m00 = 19'(signed'(in_data[15:0]));
  assign m01 = 19'(signed'(in_data[31:16]));
  assign m02 = 19'(signed'(in_data[47:32]));
  assign m10 = 19'(signed'(in_data[63:48]));
  assign m11 = 19'(signed'(in_data[79:64]));
  assign m12 = 19'(signed'(in_data[95:80]));
  assign m20 = 19'(signed'(in_data[111:96]));
  assign m21 = 19'(signed'(in_data[127:112]));
  assign m22 = 19'(signed'(in_data[143:128]));

  assign tr = m00 + m11 + m22;

  always_comb begin
    if (tr > 0) begin
      path = rmq_pkg::PATH_TRACE;
    end else if (m11 > m00) begin
      path = (m22 > m11) ? rmq_pkg::PATH_Z : rmq_pkg::PATH_Y;
    end else begin
      path = (m22 > m00) ? rmq_pkg::PATH_Z : rmq_pkg::PATH_X;
    end
    case (path)
      rmq_pkg::PATH_TRACE: begin
        r = tr + rmq_pkg::Q_ONE;
        d0 = m12 - m21; d1 = m20 - m02; d2 = m01 - m10;
      end
      rmq_pkg::PATH_X: begin
        r = rmq_pkg::Q_ONE + m00 - m11 - m22;
        d0 = m12 - m21; d1 = m01 + m10; d2 = m02 + m20;
      end
      rmq_pkg::PATH_Y: begin
        r = rmq_pkg::Q_ONE + m11 - m22 - m00;
        d0 = m20 - m02; d1 = m12 + m21; d2 = m10 + m01;
      end
      default: begin
        r = rmq_pkg::Q_ONE + m22 - m00 - m11;
        d0 = m01 - m10; d1 = m20 + m02; d2 = m21 + m12;
      end
    endcase
    // not a rotation: clamp radicand to one lsb
    if (r <= 0) r = 19'sd1;
  end

  assign d[0] = d0[17:0];
  assign d[1] = d1[17:0];
  assign d[2] = d2[17:0];

  always_comb begin
    dn = '0;
    word_next = '0;
    word_next.path = path;
    word_next.rad  = r[17:0];
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      dn = -d[l];
      word_next.sign[l] = d[l][17];
      word_next.mag[l]  = d[l][17] ? dn[16:0] : d[l][16:0];
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

// File: rtl/core/rmq_sqrt_cell.sv
// Square root cell: settles one root bit from two radicand bits.
module rmq_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rmq_pkg::sqrt_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rmq_pkg::sqrt_word_t  out_word
);

  logic                 valid;
  rmq_pkg::sqrt_word_t  word;
  rmq_pkg::sqrt_word_t  word_next;
  logic [25:0]          t;
  logic [25:0]          trial;

  assign t     = {in_word.rem, in_word.rad[17:16]};
  assign trial = {1'b0, in_word.root, 2'b01};

  always_comb begin
    word_next     = in_word;
    word_next.rad = {in_word.rad[15:0], 2'b00};
    if (t >= trial) begin
      word_next.rem  = 24'(t - trial);
      word_next.root = {in_word.root[21:0], 1'b1};
    end else begin
      word_next.rem  = t[23:0];
      word_next.root = {in_word.root[21:0], 1'b0};
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

// File: rtl/core/rmq_div_cell.sv
// Division cell: one restoring quotient bit for each of the three lanes.
module rmq_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmq_pkg::div_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rmq_pkg::div_word_t  out_word
);

  logic                valid;
  rmq_pkg::div_word_t  word;
  rmq_pkg::div_word_t  word_next;
  logic [24:0]         t [3];

  always_comb begin
    word_next = in_word;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      t[l] = {in_word.rem[l], in_word.numlo[l][22]};
      word_next.numlo[l] = {in_word.numlo[l][21:0], 1'b0};
      if (t[l] >= {1'b0, in_word.den}) begin
        word_next.rem[l] = 24'(t[l] - {1'b0, in_word.den});
        word_next.quo[l] = {in_word.quo[l][21:0], 1'b1};
      end else begin
        word_next.rem[l] = t[l][23:0];
        word_next.quo[l] = {in_word.quo[l][21:0], 1'b0};
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

// File: bench/rotation_matrix_to_quaternion_tb.sv
// Testbench for the rotation matrix to quaternion pipeline: directed and random matrices.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;

  localparam int N_RANDOM = 1730;
  localparam int LATENCY  = 48;

  typedef logic signed [15:0] q14_t;

  typedef struct {
    q14_t  qw, qx, qy, qz;
    rmq_pkg::path_t path;
  } quat_t;

  typedef struct {
    q14_t m [9];
    bit   known;   // expected value typed in below
    quat_t q;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;

  quat_t quat_q[$];
  int    mismatches = 0;
  bit    stim_done = 1'b0;

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic q14_t clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return q14_t'(v);
  endfunction

  // d * 2^20 / s, nearest, ties away from zero
  function automatic q14_t div_root(longint d, longint unsigned s);
    longint unsigned mag, quo;
    mag = (d < 0) ? longint'(-d) : d;
    quo = ((mag << 21) + s) / (s << 1);
    return clip16((d < 0) ? -longint'(quo) : longint'(quo));
  endfunction

  function automatic quat_t matrix_to_quat(q14_t m [9]);
    quat_t r;
    longint e [3][3];
    longint tr, rad;
    longint unsigned s;
    q14_t c [4];
    int i, j, k;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) e[a][b] = m[a*3+b];
    tr = e[0][0] + e[1][1] + e[2][2];
    if (tr > 0) begin
      s = int_sqrt(longint'(tr + 16384) << 28);
      c[0] = clip16((s + 128) >> 8);
      c[1] = div_root(e[1][2] - e[2][1], s);
      c[2] = div_root(e[2][0] - e[0][2], s);
      c[3] = div_root(e[0][1] - e[1][0], s);
      r.path = rmq_pkg::PATH_TRACE;
    end else begin
      i = 0;
      if (e[1][1] > e[0][0]) i = 1;
      if (e[2][2] > e[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = 16384 + e[i][i] - e[j][j] - e[k][k];
      if (rad <= 0) rad = 1;  // not a rotation: clamp to one lsb
      s = int_sqrt(rad << 28);
      c[1+i] = clip16((s + 128) >> 8);
      c[0]   = div_root(e[j][k] - e[k][j], s);
      c[1+j] = div_root(e[i][j] + e[j][i], s);
      c[1+k] = div_root(e[i][k] + e[k][i], s);
      r.path = rmq_pkg::path_t'(i + 1);
    end
    r.qw = c[0]; r.qx = c[1]; r.qy = c[2]; r.qz = c[3];
    return r;
  endfunction

  function automatic row_t mk_row(int a0, a1, a2, a3, a4, a5, a6, a7, a8);
    row_t r;
    int v [9];
    v = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    foreach (v[n]) r.m[n] = q14_t'(v[n]);
    r.known = 1'b0;
    r.q = '{default: 0, path: rmq_pkg::PATH_TRACE};
    return r;
  endfunction

  function automatic row_t mk_known(row_t r, int w, x, y, z, rmq_pkg::path_t p);
    r.known = 1'b1;
    r.q = '{qw: q14_t'(w), qx: q14_t'(x), qy: q14_t'(y), qz: q14_t'(z), path: p};
    return r;
  endfunction

  // random rotation from a random unit quaternion, optionally with noise
  function automatic row_t rand_rotation(int noise);
    row_t r;
    real w, x, y, z, n;
    real f [9];
    w = $urandom_range(0, 20000) - 10000.0;
    x = $urandom_range(0, 20000) - 10000.0;
    y = $urandom_range(0, 20000) - 10000.0;
    z = $urandom_range(0, 20000) - 10000.0;
    n = $sqrt(w*w + x*x + y*y + z*z) + 1.0;
    w /= n; x /= n; y /= n; z /= n;
    f = '{1-2*(y*y+z*z), 2*(x*y-z*w), 2*(x*z+y*w),
          2*(x*y+z*w), 1-2*(x*x+z*z), 2*(y*z-x*w),
          2*(x*z-y*w), 2*(y*z+x*w), 1-2*(x*x+y*y)};
    foreach (f[n2])
      r.m[n2] = clip16(longint'($rtoi(f[n2] * 16384.0))
                       + $urandom_range(0, 2*noise) - noise);
    r.known = 1'b0;
    return r;
  endfunction

  task automatic send_matrix(row_t r);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap > 0 && $urandom_range(0, 3) != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.m[8], r.m[7], r.m[6], r.m[5], r.m[4], r.m[3], r.m[2], r.m[1], r.m[0]};
    do @(posedge clk); while (!s_tready);
    quat_q.push_back(r.known ? r.q : matrix_to_quat(r.m));
  endtask

  initial begin
    row_t dir [$];
    row_t r;
    int sel;
    // identity and zero matrix, then half turns about each axis
    dir.push_back(mk_known(mk_row(16384, 0, 0, 0, 16384, 0, 0, 0, 16384),
                           16384, 0, 0, 0, rmq_pkg::PATH_TRACE));
    dir.push_back(mk_known(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 8192, 0, 0,
                           rmq_pkg::PATH_X));
    dir.push_back(mk_row(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    dir.push_back(mk_row(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    dir.push_back(mk_row(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    // diagonal ties: lower index wins
    dir.push_back(mk_row(-8192, 0, 0, 0, -8192, 0, 0, 0, -8192));
    dir.push_back(mk_row(-16384, 100, 0, 0, -100, 0, 0, 0, -100));
    dir.push_back(mk_row(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    // field extremes and saturation
    dir.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    dir.push_back(mk_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                         -32768));
    dir.push_back(mk_row(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0));
    dir.push_back(mk_row(-32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768,
                         32767));
    dir.push_back(mk_row(32767, -32768, -32768, -32768, -32768, 32767, 32767, 32767,
                         -32768));
    dir.push_back(mk_row(-32768, 32767, 32767, 32767, -32768, -32768, -32768, 32767,
                         -32768));
    dir.push_back(mk_row(-1, 0, 0, 0, -1, 0, 0, 0, 1));
    dir.push_back(mk_row(0, 32767, -32768, 32767, 0, 32767, -32768, -32768, 0));
    dir.push_back(mk_row(-21846, 0, 0, 0, -21846, 0, 0, 0, 32767));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (dir[n]) send_matrix(dir[n]);
    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) r = rand_rotation(0);
      else if (sel < 8) r = rand_rotation(64);
      else begin
        for (int e = 0; e < 9; e++)
          r.m[e] = (sel == 8) ? q14_t'($urandom) : q14_t'($urandom_range(0, 64) - 32);
        r.known = 1'b0;
      end
      send_matrix(r);
    end
    s_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // sink: stall for a drawn number of cycles per word, with bursts of no stall
  initial begin
    int w;
    int burst;
    burst = 0;
    @(negedge rst);
    forever begin
      if (burst > 0) begin
        burst--;
        w = 0;
      end else begin
        w = $urandom_range(0, 15);
        if ($urandom_range(0, 63) == 0) burst = $urandom_range(20, 80);
      end
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    quat_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.qw = m_tdata[15:0];
      got.qx = m_tdata[31:16];
      got.qy = m_tdata[47:32];
      got.qz = m_tdata[63:48];
      got.path = rmq_pkg::path_t'(m_tuser);
      if (quat_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = quat_q.pop_front();
        if (got.qw !== want.qw || got.qx !== want.qx || got.qy !== want.qy ||
            got.qz !== want.qz || got.path !== want.path) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (quat_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
